@@ rtl/quaternion_arithmetic_unit_macros.svh @@
// ---------------------------------------------------------------------------
// quaternion arithmetic unit assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication under reset
`define QAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/qau_pkg.sv @@
// ---------------------------------------------------------------------------
// qau_pkg
// shared codes, constants and tables of the quaternion arithmetic unit
// ---------------------------------------------------------------------------
package qau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ACTION_W       = 4;
  localparam int STATUS_W       = 2;
  localparam int OPW            = 4;

  // action codes on the input port
  localparam logic [ACTION_W-1:0] ACT_CREATE    = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_MULTIPLY  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_SCALE     = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD       = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_SUB       = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_CONJUGATE = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_NORM      = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_NORMALISE = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_INVERSE   = 4'd8;

  // decoded operation class
  typedef enum logic [OPW-1:0] {
    OP_CREATE, OP_MUL, OP_SCALE, OP_ADD, OP_SUB, OP_CONJ,
    OP_NORM, OP_NORMALISE, OP_INVERSE, OP_NONE
  } op_t;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;

  // 2^64 / (2 pi) split into a high and a low word
  localparam logic [29:0] INV2PI_HI = 30'h28BE60DB;
  localparam logic [31:0] INV2PI_LO = 32'h9391054A;

  // cordic datapath
  localparam int CORDIC_STEPS = 30;
  localparam int PHASE_FRAC   = 30;
  localparam int CW           = 34;
  localparam int ZW           = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // hamilton product sign table, bit index {lane, term}
  localparam logic [15:0] HB_NEG = 16'b0100_0010_1000_1110;

  // arctangent of 2^-i in turns, scaled by 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/qau_fifo.sv @@
// ---------------------------------------------------------------------------
// qau_fifo
// small register queue with push/full and pop/empty sides
// ---------------------------------------------------------------------------
module qau_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [AW-1:0]  wptr_r, rptr_r;
  logic [CNW-1:0] cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CNW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNW'(1);
      end
    end
  end

endmodule

@@ rtl/qau_front.sv @@
// ---------------------------------------------------------------------------
// qau_front
// accepts words, decodes the action into an operation class, queues them
// ---------------------------------------------------------------------------
module qau_front #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [qau_pkg::ACTION_W-1:0]  action,
  input  logic signed [DATA_WIDTH-1:0]  a_w,
  input  logic signed [DATA_WIDTH-1:0]  a_x,
  input  logic signed [DATA_WIDTH-1:0]  a_y,
  input  logic signed [DATA_WIDTH-1:0]  a_z,
  input  logic signed [DATA_WIDTH-1:0]  b_w,
  input  logic signed [DATA_WIDTH-1:0]  b_x,
  input  logic signed [DATA_WIDTH-1:0]  b_y,
  input  logic signed [DATA_WIDTH-1:0]  b_z,
  input  logic signed [DATA_WIDTH-1:0]  scalar,
  input  logic                          q_pop,
  output logic                          q_empty,
  output logic [qau_pkg::OPW+9*DATA_WIDTH-1:0] q_item
);
  import qau_pkg::*;

  localparam int IW = OPW + 9 * DATA_WIDTH;

  op_t           op;
  logic [IW-1:0] item;

  // action decode, unknown codes give a zero result
  always_comb begin
    unique case (action)
      ACT_CREATE:    op = OP_CREATE;
      ACT_MULTIPLY:  op = OP_MUL;
      ACT_SCALE:     op = OP_SCALE;
      ACT_ADD:       op = OP_ADD;
      ACT_SUB:       op = OP_SUB;
      ACT_CONJUGATE: op = OP_CONJ;
      ACT_NORM:      op = OP_NORM;
      ACT_NORMALISE: op = OP_NORMALISE;
      ACT_INVERSE:   op = OP_INVERSE;
      default:       op = OP_NONE;
    endcase
  end

  assign item = {scalar, b_z, b_y, b_x, b_w, a_z, a_y, a_x, a_w, op};

  // queue toward the execution side
  qau_fifo #(
    .W     (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_inq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

endmodule

@@ rtl/qau_exec.sv @@
// ---------------------------------------------------------------------------
// qau_exec
// sequenced datapath: shared multiplier, cordic, square root and divider
// ---------------------------------------------------------------------------
module qau_exec #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic [qau_pkg::OPW+9*DATA_WIDTH-1:0]   q_item,
  input  logic                                   res_full,
  output logic                                   res_push,
  output logic [qau_pkg::STATUS_W+4*DATA_WIDTH-1:0] res_word
);
  import qau_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MW   = ((DW > 32) ? DW : 32) + 1;
  localparam int PW   = 2 * MW;
  localparam int ACCW = 2 * MW + 2 * F + 4;
  localparam int N2W  = 2 * DW + 1;
  localparam int SQW  = DW + 1;
  localparam int NUMW = DW + 2 * F;
  localparam int CNTW = $clog2(NUMW + 1);

  localparam logic signed [ACCW-1:0] LMAX = {{(ACCW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] LMIN = {{(ACCW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DRAIN, S_CORDIC, S_CFIN, S_SQRT, S_DSET, S_DIV, S_SIMPLE, S_DONE
  } state_t;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic       neg;
    logic       shl;
    logic [1:0] lane;
  } tag_t;

  // saturate to a lane, top bit flags clamping
  function automatic logic [DW:0] clamp_f(input logic signed [ACCW-1:0] v);
    logic [DW:0] r;
    if (v < LMIN) begin
      r = {1'b1, LMIN[DW-1:0]};
    end else if (v > LMAX) begin
      r = {1'b1, LMAX[DW-1:0]};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  state_t                 state_r;
  op_t                    op_r;
  logic [3:0][DW-1:0]     a_r, b_r, res_r;
  logic [DW-1:0]          k_r;
  logic [3:0]             st_r;
  logic                   mph_r;
  logic signed [PW-1:0]   prod_r;
  tag_t                   tag_r;
  logic signed [ACCW-1:0] acc_r;
  logic [1:0]             quad_r;
  logic signed [CW-1:0]   cx_r, cy_r, s_r;
  logic signed [ZW-1:0]   cz_r;
  logic [CNTW-1:0]        cnt_r;
  logic [2*SQW-1:0]       srad_r;
  logic [SQW:0]           srem_r;
  logic [SQW-1:0]         sroot_r;
  logic [N2W-1:0]         dd_r, drem_r;
  logic [NUMW-1:0]        dnum_r, dq_r;
  logic                   dneg_r;
  logic [1:0]             dlane_r;
  logic                   sat_r, dz_r;

  logic signed [MW-1:0]   mul_a, mul_b;
  tag_t                   tag_nxt;
  logic                   last_step;
  logic signed [ACCW-1:0] term, sum;
  logic [DW:0]            mstore, nstore, cstore, dstore;
  logic [3:0][DW:0]       simp;
  logic signed [CW-1:0]   xs, ys, cc, ss;
  logic signed [ZW-1:0]   at;
  logic [SQW+2:0]         sq_rem2, sq_trial, sq_diff;
  logic                   sq_ge;
  logic [SQW-1:0]         sq_root_nxt;
  logic [N2W:0]           dv_rem2, dv_diff;
  logic                   dv_ge;
  logic [NUMW-1:0]        dv_q;
  logic signed [ACCW-1:0] dv_qs;
  logic [DW-1:0]          ds_lane, ds_mag;
  logic                   is_inv;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign res_push = (state_r == S_DONE) && !res_full;
  assign res_word = {dz_r ? ST_DIVZERO : (sat_r ? ST_SAT : ST_OK),
                     res_r[3], res_r[2], res_r[1], res_r[0]};
  assign is_inv   = (op_r == OP_INVERSE);

  // multiplier operand select per step
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    tag_nxt   = '0;
    last_step = 1'b0;
    if (state_r == S_MUL) begin
      tag_nxt.vld = 1'b1;
      unique case (op_r)
        OP_CREATE: begin
          if (!mph_r) begin
            mul_a         = MW'($signed(k_r));
            mul_b         = (st_r[0]) ? MW'(INV2PI_HI) : MW'(INV2PI_LO);
            tag_nxt.first = !st_r[0];
            tag_nxt.last  = st_r[0];
            tag_nxt.shl   = st_r[0];
            last_step     = st_r[0];
          end else begin
            mul_a         = MW'($signed(b_r[st_r[1:0] + 2'd1]));
            mul_b         = MW'(s_r);
            tag_nxt.first = 1'b1;
            tag_nxt.last  = 1'b1;
            tag_nxt.lane  = st_r[1:0] + 2'd1;
            last_step     = (st_r == 4'd2);
          end
        end
        OP_MUL: begin
          mul_a         = MW'($signed(a_r[st_r[1:0]]));
          mul_b         = MW'($signed(b_r[st_r[3:2] ^ st_r[1:0]]));
          tag_nxt.neg   = HB_NEG[st_r];
          tag_nxt.first = (st_r[1:0] == 2'd0);
          tag_nxt.last  = (st_r[1:0] == 2'd3);
          tag_nxt.lane  = st_r[3:2];
          last_step     = (st_r == 4'd15);
        end
        OP_SCALE: begin
          mul_a         = MW'($signed(a_r[st_r[1:0]]));
          mul_b         = MW'($signed(k_r));
          tag_nxt.first = 1'b1;
          tag_nxt.last  = 1'b1;
          tag_nxt.lane  = st_r[1:0];
          last_step     = (st_r == 4'd3);
        end
        default: begin
          mul_a         = MW'($signed(a_r[st_r[1:0]]));
          mul_b         = MW'($signed(a_r[st_r[1:0]]));
          tag_nxt.first = (st_r == 4'd0);
          tag_nxt.last  = (st_r == 4'd3);
          last_step     = (st_r == 4'd3);
        end
      endcase
    end
  end

  // accumulate the registered product
  always_comb begin
    term = ACCW'(prod_r);
    if (tag_r.shl) begin
      term = term <<< 32;
    end
    if (tag_r.neg) begin
      term = -term;
    end
    sum    = (tag_r.first ? '0 : acc_r) + term;
    mstore = clamp_f((op_r == OP_CREATE) ? (sum >>> PHASE_FRAC) : (sum >>> F));
    nstore = clamp_f(sum >>> F);
  end

  // cordic step and quadrant fold
  always_comb begin
    xs = cx_r >>> cnt_r[4:0];
    ys = cy_r >>> cnt_r[4:0];
    at = ZW'(atan_turn(cnt_r[4:0]));
    unique case (quad_r)
      2'd0: begin cc = cx_r;  ss = cy_r;  end
      2'd1: begin cc = -cy_r; ss = cx_r;  end
      2'd2: begin cc = -cx_r; ss = -cy_r; end
      default: begin cc = cy_r; ss = -cx_r; end
    endcase
    cstore = clamp_f(ACCW'(cc) >>> (PHASE_FRAC - F));
  end

  // square root digit step
  always_comb begin
    sq_rem2     = {srem_r, srad_r[2*SQW-1 -: 2]};
    sq_trial    = {1'b0, sroot_r, 2'b01};
    sq_ge       = (sq_rem2 >= sq_trial);
    sq_diff     = sq_rem2 - sq_trial;
    sq_root_nxt = {sroot_r[SQW-2:0], sq_ge};
  end

  // restoring divide step and numerator setup
  always_comb begin
    dv_rem2 = {drem_r, dnum_r[NUMW-1]};
    dv_ge   = (dv_rem2 >= {1'b0, dd_r});
    dv_diff = dv_rem2 - {1'b0, dd_r};
    dv_q    = {dq_r[NUMW-2:0], dv_ge};
    dv_qs   = ACCW'(dv_q);
    dstore  = clamp_f(dneg_r ? -dv_qs : dv_qs);
    ds_lane = a_r[dlane_r];
    ds_mag  = ds_lane[DW-1] ? (~ds_lane + DW'(1)) : ds_lane;
  end

  // add, subtract, conjugate
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      unique case (op_r)
        OP_ADD:  simp[i] = clamp_f(ACCW'($signed(a_r[i])) + ACCW'($signed(b_r[i])));
        OP_SUB:  simp[i] = clamp_f(ACCW'($signed(a_r[i])) - ACCW'($signed(b_r[i])));
        OP_CONJ: simp[i] = (i == 0) ? clamp_f(ACCW'($signed(a_r[i])))
                                    : clamp_f(-ACCW'($signed(a_r[i])));
        default: simp[i] = '0;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tag_r   <= '0;
    end else begin
      tag_r  <= tag_nxt;
      prod_r <= PW'(mul_a) * PW'(mul_b);
      if (tag_r.vld) begin
        acc_r <= sum;
      end
      // lane results of product sums
      if (tag_r.vld && tag_r.last &&
          (op_r == OP_MUL || op_r == OP_SCALE || (op_r == OP_CREATE && mph_r))) begin
        res_r[tag_r.lane] <= mstore[DW-1:0];
        sat_r             <= sat_r | mstore[DW];
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            op_r  <= op_t'(q_item[OPW-1:0]);
            for (int i = 0; i < 4; i++) begin
              a_r[i] <= q_item[OPW + i*DW +: DW];
              b_r[i] <= q_item[OPW + (4+i)*DW +: DW];
            end
            k_r   <= q_item[OPW + 8*DW +: DW];
            res_r <= '0;
            sat_r <= 1'b0;
            dz_r  <= 1'b0;
            st_r  <= '0;
            mph_r <= 1'b0;
            unique case (op_t'(q_item[OPW-1:0]))
              OP_ADD, OP_SUB, OP_CONJ, OP_NONE: state_r <= S_SIMPLE;
              default:                          state_r <= S_MUL;
            endcase
          end
        end
        S_MUL: begin
          st_r <= st_r + 4'd1;
          if (last_step) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          unique case (op_r)
            OP_CREATE: begin
              if (!mph_r) begin
                quad_r  <= sum[F+64 -: 2];
                cz_r    <= ZW'(sum[F+33 +: 30]);
                cx_r    <= CORDIC_GAIN;
                cy_r    <= '0;
                cnt_r   <= '0;
                state_r <= S_CORDIC;
              end else begin
                state_r <= S_DONE;
              end
            end
            OP_NORM: begin
              res_r[0] <= nstore[DW-1:0];
              sat_r    <= nstore[DW];
              state_r  <= S_DONE;
            end
            OP_NORMALISE, OP_INVERSE: begin
              if (sum[N2W-1:0] == '0) begin
                dz_r    <= 1'b1;
                state_r <= S_DONE;
              end else begin
                srad_r  <= (2*SQW)'(sum[N2W-1:0]);
                srem_r  <= '0;
                sroot_r <= '0;
                dd_r    <= sum[N2W-1:0];
                cnt_r   <= '0;
                dlane_r <= 2'd0;
                state_r <= is_inv ? S_DSET : S_SQRT;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_CORDIC: begin
          if (!cz_r[ZW-1]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + at;
          end
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(CORDIC_STEPS - 1)) begin
            state_r <= S_CFIN;
          end
        end
        S_CFIN: begin
          res_r[0] <= cstore[DW-1:0];
          sat_r    <= sat_r | cstore[DW];
          s_r      <= ss;
          mph_r    <= 1'b1;
          st_r     <= '0;
          state_r  <= S_MUL;
        end
        S_SQRT: begin
          srem_r  <= sq_ge ? sq_diff[SQW:0] : sq_rem2[SQW:0];
          sroot_r <= sq_root_nxt;
          srad_r  <= {srad_r[2*SQW-3:0], 2'b00};
          cnt_r   <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(SQW - 1)) begin
            dd_r    <= N2W'(sq_root_nxt);
            state_r <= S_DSET;
          end
        end
        S_DSET: begin
          dnum_r  <= is_inv ? (NUMW'(ds_mag) << (2*F)) : (NUMW'(ds_mag) << F);
          dneg_r  <= ds_lane[DW-1] ^ (is_inv && (dlane_r != 2'd0));
          drem_r  <= '0;
          dq_r    <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          drem_r <= dv_ge ? dv_diff[N2W-1:0] : dv_rem2[N2W-1:0];
          dq_r   <= dv_q;
          dnum_r <= {dnum_r[NUMW-2:0], 1'b0};
          cnt_r  <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(NUMW - 1)) begin
            res_r[dlane_r] <= dstore[DW-1:0];
            sat_r          <= sat_r | dstore[DW];
            dlane_r        <= dlane_r + 2'd1;
            state_r        <= (dlane_r == 2'd3) ? S_DONE : S_DSET;
          end
        end
        S_SIMPLE: begin
          for (int i = 0; i < 4; i++) begin
            res_r[i] <= simp[i][DW-1:0];
          end
          sat_r   <= simp[0][DW] | simp[1][DW] | simp[2][DW] | simp[3][DW];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/quaternion_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q16.16 quaternion operations behind queue-style input and result ports
// ---------------------------------------------------------------------------
// Words are accepted into a two-entry input queue while the execution
// sequencer works, and results leave through a two-entry output queue, so
// either side may stall on its own. One item occupies the sequencer until its
// result is queued. The sequencer is built around one shared multiplier
// (one product per cycle), a 30-step cordic, a one-digit-per-cycle square
// root and a one-bit-per-cycle restoring divider: add, subtract, conjugate
// and unknown actions take one simple step; scale, norm and multiply use the
// multiplier; create adds the cordic and further products; inverse divides
// each lane, and normalise takes a square root first.
module quaternion_arithmetic_unit #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [qau_pkg::ACTION_W-1:0]  in_action,
  input  logic signed [DATA_WIDTH-1:0]  in_a_w,
  input  logic signed [DATA_WIDTH-1:0]  in_a_x,
  input  logic signed [DATA_WIDTH-1:0]  in_a_y,
  input  logic signed [DATA_WIDTH-1:0]  in_a_z,
  input  logic signed [DATA_WIDTH-1:0]  in_b_w,
  input  logic signed [DATA_WIDTH-1:0]  in_b_x,
  input  logic signed [DATA_WIDTH-1:0]  in_b_y,
  input  logic signed [DATA_WIDTH-1:0]  in_b_z,
  input  logic signed [DATA_WIDTH-1:0]  in_scalar,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [DATA_WIDTH-1:0]  out_r_w,
  output logic signed [DATA_WIDTH-1:0]  out_r_x,
  output logic signed [DATA_WIDTH-1:0]  out_r_y,
  output logic signed [DATA_WIDTH-1:0]  out_r_z,
  output logic [qau_pkg::STATUS_W-1:0]  out_status
);
  import qau_pkg::*;

  localparam int IW = OPW + 9 * DATA_WIDTH;
  localparam int RW = STATUS_W + 4 * DATA_WIDTH;

  logic          q_empty, q_pop;
  logic [IW-1:0] q_item;
  logic          res_push, res_full;
  logic [RW-1:0] res_word, out_word;

  // front: accept and decode
  qau_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .action  (in_action),
    .a_w     (in_a_w),
    .a_x     (in_a_x),
    .a_y     (in_a_y),
    .a_z     (in_a_z),
    .b_w     (in_b_w),
    .b_x     (in_b_x),
    .b_y     (in_b_y),
    .b_z     (in_b_z),
    .scalar  (in_scalar),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  // back: execution sequencer
  qau_exec #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .res_full (res_full),
    .res_push (res_push),
    .res_word (res_word)
  );

  // result queue
  qau_fifo #(
    .W     (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

  assign out_r_w    = out_word[0*DATA_WIDTH +: DATA_WIDTH];
  assign out_r_x    = out_word[1*DATA_WIDTH +: DATA_WIDTH];
  assign out_r_y    = out_word[2*DATA_WIDTH +: DATA_WIDTH];
  assign out_r_z    = out_word[3*DATA_WIDTH +: DATA_WIDTH];
  assign out_status = out_word[4*DATA_WIDTH +: STATUS_W];

endmodule

@@ rtl/qau_checker.sv @@
// ---------------------------------------------------------------------------
// qau_checker
// port-level checks of the quaternion arithmetic unit, bound to the top
// ---------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_macros.svh"

module qau_checker #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic signed [DATA_WIDTH-1:0]  out_r_w,
  input logic signed [DATA_WIDTH-1:0]  out_r_x,
  input logic signed [DATA_WIDTH-1:0]  out_r_y,
  input logic signed [DATA_WIDTH-1:0]  out_r_z,
  input logic [qau_pkg::STATUS_W-1:0]  out_status
);
  import qau_pkg::*;

  localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // status code is one of the defined ones
  `QAU_ASSERT_NOW(a_status_code, !out_empty, out_status == ST_OK || out_status == ST_DIVZERO || out_status == ST_SAT, "undefined status code")

  // a zero divisor gives an all-zero quaternion
  `QAU_ASSERT_NOW(a_divzero_zero, !out_empty && out_status == ST_DIVZERO, out_r_w == '0 && out_r_x == '0 && out_r_y == '0 && out_r_z == '0, "nonzero lanes on zero divisor")

  // saturation shows at least one clamped lane
  `QAU_ASSERT_NOW(a_sat_lane, !out_empty && out_status == ST_SAT, out_r_w == VMAX || out_r_w == VMIN || out_r_x == VMAX || out_r_x == VMIN || out_r_y == VMAX || out_r_y == VMIN || out_r_z == VMAX || out_r_z == VMIN, "saturated status without clamped lane")

  // a waiting result holds until taken
  `QAU_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_r_w) && $stable(out_status), "result changed while stalled")

endmodule

bind quaternion_arithmetic_unit qau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qau_checker (.*);

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// quaternion arithmetic unit testbench
// Drives directed and random quaternion words through the queue-style ports.
// An in-bench bit-exact model predicts each result, and every popped word
// is compared lane by lane and on status.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qau_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int NUM_RANDOM = 1000;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic signed [127:0] INV_TWO_PI = 128'sh28BE60DB9391054A;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam logic signed [127:0] LANE_MAX = (128'sd1 <<< (DW - 1)) - 1;
  localparam logic signed [127:0] LANE_MIN = -(128'sd1 <<< (DW - 1));
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE = 1 <<< FB;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic signed [DW-1:0] a [4];
    logic signed [DW-1:0] b [4];
    logic signed [DW-1:0] scalar;
  } quat_op_t;

  typedef struct {
    logic signed [DW-1:0] r [4];
    logic [STATUS_W-1:0] status;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [ACTION_W-1:0] in_action = '0;
  logic signed [DW-1:0] in_a_w = '0, in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [DW-1:0] in_b_w = '0, in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [DW-1:0] in_scalar = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [DW-1:0] out_r_w, out_r_x, out_r_y, out_r_z;
  logic [STATUS_W-1:0] out_status;

  quat_op_t pending_ops[$];
  quat_res_t expected_results[$];
  quat_op_t word_on_bus;
  logic word_taken = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int stall_cycles = 0;

  quaternion_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_action(in_action),
    .in_a_w(in_a_w), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_w(in_b_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_scalar(in_scalar),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_r_w(out_r_w), .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z),
    .out_status(out_status)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arctangent of 2^-i in turns
  function automatic longint atan_step(input int i);
    longint tbl [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    return tbl[i];
  endfunction

  // saturate one lane to the word width
  function automatic logic signed [DW-1:0] clamp_lane(input logic signed [127:0] v,
                                                      inout bit sat);
    if (v < LANE_MIN) begin
      sat = 1'b1;
      return VMIN;
    end
    if (v > LANE_MAX) begin
      sat = 1'b1;
      return VMAX;
    end
    return v[DW-1:0];
  endfunction

  // floor square root of a nonnegative value below 2^66
  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // expected result word of one quaternion operation
  function automatic quat_res_t quat_predict(input quat_op_t op);
    logic signed [127:0] a [4];
    logic signed [127:0] b [4];
    logic signed [127:0] r [4];
    logic signed [127:0] k, n2, p, len, num;
    logic [31:0] phase;
    longint x, y, z, xs, ys, c, s;
    bit sat, divzero;
    quat_res_t res;
    sat = 1'b0;
    divzero = 1'b0;
    n2 = 0;
    k = op.scalar;
    for (int i = 0; i < 4; i++) begin
      a[i] = op.a[i];
      b[i] = op.b[i];
      r[i] = 0;
      n2 += a[i] * a[i];
    end
    case (op.action)
      ACT_CREATE: begin
        // half angle to phase in turns, then cordic over one quadrant
        p = (k * INV_TWO_PI) >>> (FB + 33);
        phase = p[31:0];
        x = GAIN_Q30;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < 30; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (z >= 0) begin
            x -= ys; y += xs; z -= atan_step(i);
          end else begin
            x += ys; y -= xs; z += atan_step(i);
          end
        end
        case (phase[31:30])
          2'd0: begin c = x; s = y; end
          2'd1: begin c = -y; s = x; end
          2'd2: begin c = -x; s = -y; end
          default: begin c = y; s = -x; end
        endcase
        r[0] = 128'(c) >>> (30 - FB);
        for (int i = 1; i < 4; i++) r[i] = (b[i] * 128'(s)) >>> 30;
      end
      ACT_MULTIPLY: begin
        r[0] = (a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]) >>> FB;
        r[1] = (a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]) >>> FB;
        r[2] = (a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]) >>> FB;
        r[3] = (a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]) >>> FB;
      end
      ACT_SCALE: for (int i = 0; i < 4; i++) r[i] = (a[i] * k) >>> FB;
      ACT_ADD:   for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      ACT_SUB:   for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      ACT_CONJUGATE: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = -a[i];
      end
      ACT_NORM: r[0] = n2 >>> FB;
      ACT_NORMALISE, ACT_INVERSE: begin
        if (n2 == 0) begin
          divzero = 1'b1;
        end else if (op.action == ACT_NORMALISE) begin
          len = floor_sqrt(n2);
          for (int i = 0; i < 4; i++) r[i] = (a[i] <<< FB) / len;
        end else begin
          for (int i = 0; i < 4; i++) begin
            num = a[i] <<< (2 * FB);
            r[i] = (i == 0 ? num : -num) / n2;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = clamp_lane(r[i], sat);
    res.status = divzero ? ST_DIVZERO : (sat ? ST_SAT : ST_OK);
    return res;
  endfunction

  // lane value: mostly small Q16.16, some full range and extremes
  function automatic logic signed [DW-1:0] rand_lane();
    logic signed [DW-1:0] pick [5] = '{VMAX, VMIN, 0, 1, -1};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1, 2: return $signed($urandom_range(0, 1 << 20)) - (1 <<< 19);
      default: return pick[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic quat_op_t make_op(input logic [ACTION_W-1:0] act,
                                       input logic signed [DW-1:0] av,
                                       input logic signed [DW-1:0] bv,
                                       input logic signed [DW-1:0] sv);
    quat_op_t op;
    op.action = act;
    for (int i = 0; i < 4; i++) begin
      op.a[i] = av;
      op.b[i] = bv;
    end
    op.scalar = sv;
    return op;
  endfunction

  // stimulus: directed words, then random ones
  initial begin
    quat_op_t op;
    pending_ops.push_back(make_op(ACT_CREATE, 0, ONE, 0));
    pending_ops.push_back(make_op(ACT_CREATE, 0, ONE, 32'sd205887));
    pending_ops.push_back(make_op(ACT_CREATE, 0, VMAX, VMAX));
    pending_ops.push_back(make_op(ACT_CREATE, 0, VMIN, VMIN));
    pending_ops.push_back(make_op(ACT_MULTIPLY, ONE, ONE, 0));
    pending_ops.push_back(make_op(ACT_MULTIPLY, VMAX, VMIN, 0));
    pending_ops.push_back(make_op(ACT_SCALE, VMIN, 0, VMIN));
    pending_ops.push_back(make_op(ACT_SCALE, ONE, 0, -ONE));
    pending_ops.push_back(make_op(ACT_ADD, VMAX, VMAX, 0));
    pending_ops.push_back(make_op(ACT_ADD, VMIN, VMIN, 0));
    pending_ops.push_back(make_op(ACT_SUB, VMIN, VMAX, 0));
    pending_ops.push_back(make_op(ACT_SUB, ONE, -ONE, 0));
    pending_ops.push_back(make_op(ACT_CONJUGATE, VMIN, 0, 0));
    pending_ops.push_back(make_op(ACT_CONJUGATE, VMAX, 0, 0));
    pending_ops.push_back(make_op(ACT_NORM, VMIN, 0, 0));
    pending_ops.push_back(make_op(ACT_NORM, ONE, 0, 0));
    pending_ops.push_back(make_op(ACT_NORMALISE, 0, 0, 0));
    pending_ops.push_back(make_op(ACT_NORMALISE, VMIN, 0, 0));
    pending_ops.push_back(make_op(ACT_NORMALISE, 1, 0, 0));
    pending_ops.push_back(make_op(ACT_INVERSE, 0, 0, 0));
    pending_ops.push_back(make_op(ACT_INVERSE, 1, 0, 0));
    pending_ops.push_back(make_op(ACT_INVERSE, VMAX, 0, 0));
    pending_ops.push_back(make_op(ACT_INVERSE + 4'd1, VMAX, VMAX, VMAX));
    pending_ops.push_back(make_op('1, ONE, ONE, ONE));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // slow division ops are kept rare so the run stays short
      case ($urandom_range(0, 19))
        0: op.action = ACT_NORMALISE;
        1: op.action = ACT_INVERSE;
        2: op.action = $urandom_range(ACT_INVERSE + 1, 15);
        default: op.action = $urandom_range(ACT_CREATE, ACT_NORM);
      endcase
      for (int i = 0; i < 4; i++) begin
        op.a[i] = rand_lane();
        op.b[i] = rand_lane();
      end
      op.scalar = rand_lane();
      pending_ops.push_back(op);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // poll until every word is sent and every result is checked
    while (pending_ops.size() != 0 || in_push || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // input driver: next word at the falling edge
  always @(negedge clk) begin
    bit busy;
    bit burst;
    busy = in_push && !word_taken;
    burst = words_sent > 300 && words_sent < 500;
    if (!rst_n || busy) begin
      // hold the current word
    end else if (pending_ops.size() != 0 && (burst || $urandom_range(0, 99) >= 33)) begin
      word_on_bus = pending_ops.pop_front();
      in_push <= 1'b1;
      in_action <= word_on_bus.action;
      in_a_w <= word_on_bus.a[0];
      in_a_x <= word_on_bus.a[1];
      in_a_y <= word_on_bus.a[2];
      in_a_z <= word_on_bus.a[3];
      in_b_w <= word_on_bus.b[0];
      in_b_x <= word_on_bus.b[1];
      in_b_y <= word_on_bus.b[2];
      in_b_z <= word_on_bus.b[3];
      in_scalar <= word_on_bus.scalar;
    end else begin
      in_push <= 1'b0;
    end
    // result side stalls at random, never during the burst
    out_pop <= rst_n && (burst || $urandom_range(0, 99) >= 33);
  end

  // accept words and check results at the rising edge
  always @(posedge clk) begin
    quat_res_t exp_res;
    logic signed [DW-1:0] got [4];
    bit moved;
    moved = 1'b0;
    word_taken <= rst_n && in_push && !in_full;
    if (rst_n && in_push && !in_full) begin
      expected_results.push_back(quat_predict(word_on_bus));
      words_sent <= words_sent + 1;
      moved = 1'b1;
    end
    if (rst_n && out_pop && !out_empty) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        got = '{out_r_w, out_r_x, out_r_y, out_r_z};
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== exp_res.r[i]) begin
            $error("lane r_%s: expected %0d, actual %0d", i == 0 ? "w" : i == 1 ? "x" :
                   i == 2 ? "y" : "z", exp_res.r[i], got[i]);
            errors++;
          end
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          errors++;
        end
      end
    end
    // watchdog on cycles with no transfer
    stall_cycles <= moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/qau_pkg.sv
rtl/qau_fifo.sv
rtl/qau_front.sv
rtl/qau_exec.sv
rtl/quaternion_arithmetic_unit.sv
rtl/qau_checker.sv
sim/tb_top.sv
